// ===== hdl/sla_pkg.sv =====
// ---------------------------------------------------------------------------
// Status LED animator package
// Types and constants for the status LED animator.
// ---------------------------------------------------------------------------
package sla_pkg;

    typedef enum logic [1:0] {
        MODE_BREATHE = 2'd0,
        MODE_SOLID   = 2'd1,
        MODE_BLINK   = 2'd2
    } anim_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_UPDATE = 3'd1,
        ST_MUL1   = 3'd2,
        ST_MUL2   = 3'd3,
        ST_WRITE  = 3'd4
    } fsm_state_t;

    localparam logic [2:0] CODE_BOOT   = 3'd0;
    localparam logic [2:0] CODE_WIFI   = 3'd1;
    localparam logic [2:0] CODE_IDLE   = 3'd2;
    localparam logic [2:0] CODE_STREAM = 3'd3;
    localparam logic [2:0] CODE_LINK   = 3'd4;
    localparam logic [2:0] CODE_ERROR  = 3'd5;

    localparam logic [23:0] COLOR_BLUE   = 24'h0000FF;
    localparam logic [23:0] COLOR_ORANGE = 24'hFFA500;
    localparam logic [23:0] COLOR_CYAN   = 24'h00FFFF;
    localparam logic [23:0] COLOR_PURPLE = 24'h800080;
    localparam logic [23:0] COLOR_GREEN  = 24'h00FF00;
    localparam logic [23:0] COLOR_RED    = 24'hFF0000;
    localparam logic [23:0] COLOR_BLACK  = 24'h000000;

    localparam logic [7:0] FULL_SCALE   = 8'd255;
    localparam logic [8:0] STEP_PEAK    = 9'd255;
    localparam logic [8:0] STEP_FLOOR   = 9'd20;
    localparam logic [8:0] STEP_DELTA   = 9'd2;
    localparam logic [8:0] BLINK_LAST   = 9'd20;
    localparam logic [8:0] BLINK_ON     = 9'd10;
    localparam logic [8:0] STEP_MAX     = 9'd256;

endpackage

// ===== hdl/sla_lane.sv =====
// ---------------------------------------------------------------------------
// Status LED animator scaling lane
// Bit-serial shift-add multiplier followed by an exact divide by 255 with
// saturation at 255. One multiplier bit is consumed per cycle.
// ---------------------------------------------------------------------------
module sla_lane (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] a,
    input  logic [8:0] b,
    output logic       done,
    output logic [7:0] q
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [7:0] a_reg, a_next;
    logic [8:0] hi_reg, hi_next;
    logic [8:0] lo_reg, lo_next;

    logic [9:0]  sum;
    logic [15:0] prod;
    logic [16:0] div_sum;
    logic [8:0]  quo;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        sum       = {1'b0, hi_reg} + (lo_reg[0] ? {2'b00, a_reg} : 10'd0);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            a_next    = a;
            hi_next   = 9'd0;
            lo_next   = b;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[9:1];
            lo_next  = {sum[0], lo_reg[8:1]};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd8)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    // The product never exceeds 255 * 256, where this reciprocal form is exact.
    assign prod    = {hi_reg[6:0], lo_reg};
    assign div_sum = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    assign quo     = div_sum[16:8];
    assign q       = quo[8] ? 8'hFF : quo[7:0];
    assign done    = done_reg;

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("lane reports done while still busy");

endmodule

// ===== hdl/status_led_animator.sv =====
// ---------------------------------------------------------------------------
// Status LED animator
// Selects a status color and animation, steps a breathe or blink animation on
// each tick, and scales the color by the animation gain and by the global brightness.
// ---------------------------------------------------------------------------
// An accepted input transaction passes the update state, two multiply passes and
// the write state before the output is valid. Items are taken one at a time: each
// takes two passes of the bit-serial multiply in each of three channel lanes.
// A finished result waits in the output register while the next item is taken.
// Reset: brightness 255, breathe mode, blue color, step 0 counting up.
module status_led_animator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] state_code, [7:3] zero
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    sla_pkg::fsm_state_t state_reg, state_next;
    sla_pkg::anim_mode_t mode_reg, mode_sel;

    logic [7:0]  bright_reg;
    logic [23:0] color_reg, color_sel;
    logic [8:0]  step_reg, step_new, step_base, step_inc;
    logic        rising_reg, rising_new, rising_base;
    logic        req_reg;
    logic [2:0]  code_reg;
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg;

    logic       set_req;
    logic [8:0] gain;
    logic       lane_start;
    logic       out_load;
    logic [2:0] lane_done;
    logic [7:0] lane_q [3];
    logic [7:0] lane_a [3];
    logic [8:0] lane_b;

    assign set_req = !req_reg;

    always_comb
    begin
        mode_sel  = mode_reg;
        color_sel = color_reg;
        if (set_req)
        begin
            case (code_reg)
                sla_pkg::CODE_BOOT:
                begin
                    mode_sel  = sla_pkg::MODE_BREATHE;
                    color_sel = sla_pkg::COLOR_BLUE;
                end
                sla_pkg::CODE_WIFI:
                begin
                    mode_sel  = sla_pkg::MODE_BREATHE;
                    color_sel = sla_pkg::COLOR_ORANGE;
                end
                sla_pkg::CODE_IDLE:
                begin
                    mode_sel  = sla_pkg::MODE_SOLID;
                    color_sel = sla_pkg::COLOR_CYAN;
                end
                sla_pkg::CODE_STREAM:
                begin
                    mode_sel  = sla_pkg::MODE_SOLID;
                    color_sel = sla_pkg::COLOR_PURPLE;
                end
                sla_pkg::CODE_LINK:
                begin
                    mode_sel  = sla_pkg::MODE_BLINK;
                    color_sel = sla_pkg::COLOR_GREEN;
                end
                sla_pkg::CODE_ERROR:
                begin
                    mode_sel  = sla_pkg::MODE_BLINK;
                    color_sel = sla_pkg::COLOR_RED;
                end
                default:
                begin
                    color_sel = sla_pkg::COLOR_BLACK;
                end
            endcase
        end
    end

    always_comb
    begin
        step_base   = set_req ? 9'd0 : step_reg;
        rising_base = set_req ? 1'b1 : rising_reg;
        step_inc    = step_base + 9'd1;
        step_new    = step_base;
        rising_new  = rising_base;
        gain        = {1'b0, sla_pkg::FULL_SCALE};
        case (mode_sel)
            sla_pkg::MODE_BREATHE:
            begin
                if (rising_base)
                begin
                    step_new   = step_base + sla_pkg::STEP_DELTA;
                    rising_new = !(step_new >= sla_pkg::STEP_PEAK);
                end
                else
                begin
                    step_new   = step_base - sla_pkg::STEP_DELTA;
                    rising_new = (step_new <= sla_pkg::STEP_FLOOR);
                end
                gain = step_new;
            end
            sla_pkg::MODE_BLINK:
            begin
                step_new = (step_inc > sla_pkg::BLINK_LAST) ? 9'd0 : step_inc;
                if (step_new >= sla_pkg::BLINK_ON)
                begin
                    gain = 9'd0;
                end
            end
            default:
            begin
                gain = {1'b0, sla_pkg::FULL_SCALE};
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sla_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sla_pkg::ST_UPDATE;
                end
            end
            sla_pkg::ST_UPDATE:
            begin
                state_next = sla_pkg::ST_MUL1;
            end
            sla_pkg::ST_MUL1:
            begin
                if (lane_done[0])
                begin
                    state_next = sla_pkg::ST_MUL2;
                end
            end
            sla_pkg::ST_MUL2:
            begin
                if (lane_done[0])
                begin
                    state_next = sla_pkg::ST_WRITE;
                end
            end
            sla_pkg::ST_WRITE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = sla_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sla_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        lane_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            sla_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            sla_pkg::ST_UPDATE:
            begin
                lane_start = 1'b1;
            end
            sla_pkg::ST_MUL1:
            begin
                lane_start = lane_done[0];
            end
            sla_pkg::ST_WRITE:
            begin
                out_load = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == sla_pkg::ST_UPDATE)
        begin
            lane_a[0] = color_sel[23:16];
            lane_a[1] = color_sel[15:8];
            lane_a[2] = color_sel[7:0];
            lane_b    = gain;
        end
        else
        begin
            lane_a[0] = lane_q[0];
            lane_a[1] = lane_q[1];
            lane_a[2] = lane_q[2];
            lane_b    = {1'b0, bright_reg};
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        sla_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .start (lane_start),
            .a     (lane_a[i]),
            .b     (lane_b),
            .done  (lane_done[i]),
            .q     (lane_q[i])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sla_pkg::ST_IDLE;
            bright_reg    <= sla_pkg::FULL_SCALE;
            mode_reg      <= sla_pkg::MODE_BREATHE;
            color_reg     <= sla_pkg::COLOR_BLUE;
            step_reg      <= 9'd0;
            rising_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                bright_reg <= cfg_data;
            end
            if (state_reg == sla_pkg::ST_UPDATE)
            begin
                mode_reg   <= mode_sel;
                color_reg  <= color_sel;
                step_reg   <= step_new;
                rising_reg <= rising_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg  <= s_tuser;
            code_reg <= s_tdata[2:0];
        end
        if (out_load)
        begin
            out_data_reg <= {lane_q[2], lane_q[1], lane_q[0]};
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    a_accept_starts_update: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == sla_pkg::ST_UPDATE)
        else $error("accepted transaction did not start an update");

    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        lane_done == 3'b000 || lane_done == 3'b111)
        else $error("channel lanes out of step");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= sla_pkg::STEP_MAX)
        else $error("breathe step beyond its peak");

    a_blink_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == sla_pkg::MODE_BLINK |-> step_reg <= sla_pkg::BLINK_LAST)
        else $error("blink step out of range");

    a_load_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> s_tready && m_tvalid)
        else $error("output load did not return to idle with valid result");

endmodule
